[design/bsfe_pkg.sv]
package bsfe_pkg;

  // Item kinds on the input side
  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_STOP   = 2'd1,
    REG_ESCAPE = 2'd2,
    REG_NOOP   = 2'd3
  } reg_idx_e;

  localparam logic [7:0] StartTokenRst  = 8'd2;
  localparam logic [7:0] StopTokenRst   = 8'd3;
  localparam logic [7:0] EscapeTokenRst = 8'd16;
  localparam logic [7:0] NoopCodeRst    = 8'd0;

  // Most line bytes one item can cause
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  // One expanded item: line bytes in order and how many are valid
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } job_t;

endpackage

[design/bsfe_front.sv]
module bsfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                take_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          seq_number_i,
  input  logic [7:0]          data_byte_i,
  output logic                job_push_o,
  output bsfe_pkg::job_t      job_o
);
  import bsfe_pkg::*;

  logic [7:0] start_tok_q, stop_tok_q, esc_tok_q, noop_q;
  logic [7:0] prev_q, prev_d;
  logic [7:0] seq_q, seq_d;
  logic       start_pend_q, start_pend_d;
  logic       end_pend_q, end_pend_d;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_tok_q <= StartTokenRst;
      stop_tok_q  <= StopTokenRst;
      esc_tok_q   <= EscapeTokenRst;
      noop_q      <= NoopCodeRst;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_START:  start_tok_q <= cfg_data_i;
        REG_STOP:   stop_tok_q  <= cfg_data_i;
        REG_ESCAPE: esc_tok_q   <= cfg_data_i;
        REG_NOOP:   noop_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Expand one item into its line bytes and next framing state
  always_comb begin
    job_t            job;
    logic [CntW-1:0] n;
    logic [7:0]      pv;
    job          = '0;
    n            = '0;
    pv           = prev_q;
    prev_d       = prev_q;
    seq_d        = seq_q;
    start_pend_d = start_pend_q;
    end_pend_d   = end_pend_q;
    case (kind_e'(kind_i))
      KIND_BEGIN: begin
        prev_d       = '0;
        seq_d        = seq_number_i;
        start_pend_d = 1'b1;
        end_pend_d   = 1'b0;
      end
      KIND_DATA: begin
        if (start_pend_q) begin
          job.bytes[IdxW'(n)] = start_tok_q;
          n = n + 1'b1;
          job.bytes[IdxW'(n)] = start_tok_q;
          n = n + 1'b1;
          if (seq_q == esc_tok_q || (seq_q == stop_tok_q && pv == stop_tok_q)) begin
            job.bytes[IdxW'(n)] = esc_tok_q;
            n = n + 1'b1;
          end
          job.bytes[IdxW'(n)] = seq_q;
          n = n + 1'b1;
          pv           = seq_q;
          start_pend_d = 1'b0;
          end_pend_d   = 1'b1;
        end
        if (data_byte_i == esc_tok_q ||
            (data_byte_i == stop_tok_q && pv == stop_tok_q)) begin
          job.bytes[IdxW'(n)] = esc_tok_q;
          n = n + 1'b1;
        end
        job.bytes[IdxW'(n)] = data_byte_i;
        n = n + 1'b1;
        prev_d = data_byte_i;
      end
      KIND_END: begin
        if (end_pend_q) begin
          job.bytes[0] = noop_q;
          job.bytes[1] = stop_tok_q;
          job.bytes[2] = stop_tok_q;
          n = CntW'(3);
        end
      end
      default: ;
    endcase
    job.cnt    = n;
    job_o      = job;
    job_push_o = take_i && (n != '0);
  end

  // Advance framing state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      seq_q        <= '0;
      start_pend_q <= 1'b0;
      end_pend_q   <= 1'b0;
    end else if (take_i) begin
      prev_q       <= prev_d;
      seq_q        <= seq_d;
      start_pend_q <= start_pend_d;
      end_pend_q   <= end_pend_d;
    end
  end

endmodule

[design/bsfe_queue.sv]
module bsfe_queue #(
  parameter int unsigned QDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bsfe_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bsfe_pkg::job_t head_o
);
  import bsfe_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned FillW = $clog2(QDepth + 1);

  job_t             mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(QDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

[design/bsfe_back.sv]
module bsfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  bsfe_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     line_byte_o,
  output logic           last_o
);
  import bsfe_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic            load, at_end;

  assign empty_o     = !out_vld_q;
  assign line_byte_o = out_byte_q;
  assign last_o      = out_last_q;

  // Load the next line byte when the output register frees up
  always_comb begin
    load       = !job_empty_i && (!out_vld_q || pop_i);
    at_end     = (CntW'(idx_q) + 1'b1 == job_i.cnt);
    idx_d      = idx_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    job_pop_o  = 1'b0;
    if (load) begin
      out_vld_d  = 1'b1;
      out_byte_d = job_i.bytes[idx_q];
      out_last_d = at_end;
      if (at_end) begin
        idx_d     = '0;
        job_pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  // Hold payload of the output register
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

[design/byte_stuffing_frame_encoder.sv]
// A line byte is stored in the job queue and then in the output register before it
// shows on the result ports. Throughput: one line byte per cycle out of the output
// register while pop is held and jobs wait; an item causes up to six line bytes,
// while begin and other items without bytes push no job into the queue.
// A job queue of QDepth expanded items parts the classifier from the serializer.
// Reset (rst_ni low, asynchronous) empties the queue, clears framing state and
// loads the token registers with their default values.
module byte_stuffing_frame_encoder #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind_i,
  input  logic [7:0] seq_number_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] line_byte_o,
  output logic       last_o
);
  import bsfe_pkg::*;

  logic  take;
  logic  job_push, job_pop, job_empty, job_full;
  job_t  job_in, job_head;

  assign cfg_ready_o = 1'b1;
  assign full        = job_full;
  assign take        = push && !job_full;

  bsfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .take_i       (take),
    .kind_i       (kind_i),
    .seq_number_i (seq_number_i),
    .data_byte_i  (data_byte_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  bsfe_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .head_o  (job_head)
  );

  bsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .line_byte_o (line_byte_o),
    .last_o      (last_o)
  );

endmodule
